>>> rtl/prlff_pkg.sv
package prlff_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [DataW-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] S32_MIN = 32'sh8000_0000;

  localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_LO = 48'shFFFF_8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_GAIN_FF,
    CFG_RATE_UP,
    CFG_RATE_DOWN,
    CFG_DRIVE_MAX,
    CFG_DRIVE_MIN
  } cfg_idx_t;

  // saturate a sign-extended wide value to 32 bits
  function automatic logic signed [DataW-1:0] sat32(input logic signed [47:0] v);
    logic signed [DataW-1:0] res;
    if (v > SAT_HI) begin
      res = S32_MAX;
    end else if (v < SAT_LO) begin
      res = S32_MIN;
    end else begin
      res = v[DataW-1:0];
    end
    return res;
  endfunction

  // Q16.16 multiply: exact 64-bit product, floor shift by 16, saturate
  function automatic logic signed [DataW-1:0] qmul(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32($signed(p[63:16]));
  endfunction

endpackage

>>> rtl/pid_rate_limited_feedforward_core.sv
// PID step with reference rate limiting, feed-forward and integrator clamp,
// signed Q16.16 throughout.
// Input channel (in_valid/in_ready): one request per control step; command 0
// runs a step on reference/measured, command 1 clears the reference and error
// history (integrator kept) and answers with an all-zero result.
// Result channel (out_valid/out_ready): drive, loop_error and two clamp flags,
// one result per request, in request order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index;
// write only while no request is in flight.
// Six register stages: input, rate limiter, error/difference, multipliers,
// integrator, output. Throughput: one request per cycle while the receiver
// keeps taking results. The history registers close their loops inside one
// stage each (limiter, error, integrator).
// A stalled receiver holds the output register; each stage keeps taking
// requests until the one ahead of it is full, so up to six requests can sit
// in the pipe before in_ready drops.
// Reset: all stages empty, history and integrator zero, registers at defaults.
module pid_rate_limited_feedforward_core
  import prlff_pkg::*;
#(
  parameter logic signed [31:0] INTEGRAL_UPPER = 32'sh7FFF_FFFF,
  parameter logic signed [31:0] INTEGRAL_LOWER = 32'sh8000_0000
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic signed [DataW-1:0]   in_reference,
  input  logic signed [DataW-1:0]   in_measured,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DataW-1:0]   out_drive,
  output logic signed [DataW-1:0]   out_loop_error,
  output logic                      out_drive_clamped,
  output logic                      out_integral_clamped,

  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [DataW-1:0]          cfg_wdata
);

  // configuration
  logic signed [DataW-1:0] gain_p_r, gain_i_r, gain_d_r, gain_ff_r;
  logic signed [DataW-1:0] rate_up_r, rate_dn_r, drive_max_r, drive_min_r;

  // history
  logic signed [DataW-1:0] last_lim_r, last_err_r, integ_r;

  // stage valids and advance enables
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en0, en1, en2, en3, en4, en5;

  // stage payloads
  logic                    s0_cmd_r;
  logic signed [DataW-1:0] s0_ref_r, s0_meas_r;
  logic                    s1_cmd_r;
  logic signed [DataW-1:0] s1_lim_r, s1_meas_r;
  logic                    s2_cmd_r;
  logic signed [DataW-1:0] s2_lim_r, s2_err_r, s2_derr_r;
  logic                    s3_cmd_r;
  logic signed [DataW-1:0] s3_err_r, s3_p_r, s3_i_r, s3_d_r, s3_f_r;
  logic                    s4_cmd_r, s4_iclamp_r;
  logic signed [DataW-1:0] s4_err_r;
  logic signed [33:0]      s4_pdf_r;
  logic signed [DataW-1:0] out_drive_r, out_err_r;
  logic                    out_dclamp_r, out_iclamp_r;

  // combinational next values
  logic signed [32:0]      diff_nxt, lim_up_sum, lim_dn_sum;
  logic signed [DataW-1:0] lim_nxt;
  logic signed [DataW-1:0] err_nxt, derr_nxt;
  logic signed [DataW-1:0] isum_nxt, integ_nxt;
  logic                    iclamp_nxt;
  logic signed [33:0]      pdf_nxt;
  logic signed [DataW-1:0] sum_nxt, drive_nxt;
  logic                    dclamp_nxt;

  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_ready = en0;

  // stage 1: rate limiter against the previous limited reference
  always_comb begin
    diff_nxt   = 33'(s0_ref_r) - 33'(last_lim_r);
    lim_up_sum = 33'(last_lim_r) + 33'(rate_up_r);
    lim_dn_sum = 33'(last_lim_r) + 33'(rate_dn_r);
    if (diff_nxt > 33'(rate_up_r)) begin
      lim_nxt = sat32(48'(lim_up_sum));
    end else if (diff_nxt < 33'(rate_dn_r)) begin
      lim_nxt = sat32(48'(lim_dn_sum));
    end else begin
      lim_nxt = s0_ref_r;
    end
  end

  // stage 2: error and its step difference
  always_comb begin
    err_nxt  = sat32(48'(33'(s1_lim_r) - 33'(s1_meas_r)));
    derr_nxt = sat32(48'(33'(err_nxt) - 33'(last_err_r)));
  end

  // stage 4: integrator accumulate and clamp, partial sum of the other terms
  always_comb begin
    isum_nxt   = sat32(48'(33'(integ_r) + 33'(s3_i_r)));
    integ_nxt  = isum_nxt;
    iclamp_nxt = 1'b0;
    if (isum_nxt > INTEGRAL_UPPER) begin
      integ_nxt  = INTEGRAL_UPPER;
      iclamp_nxt = 1'b1;
    end else if (isum_nxt < INTEGRAL_LOWER) begin
      integ_nxt  = INTEGRAL_LOWER;
      iclamp_nxt = 1'b1;
    end
    pdf_nxt = 34'(s3_p_r) + 34'(s3_d_r) + 34'(s3_f_r);
  end

  // stage 5: total and drive clamp; integ_r already holds this item's value
  always_comb begin
    sum_nxt    = sat32(48'(35'(s4_pdf_r) + 35'(integ_r)));
    drive_nxt  = sum_nxt;
    dclamp_nxt = 1'b0;
    if (sum_nxt > drive_max_r) begin
      drive_nxt  = drive_max_r;
      dclamp_nxt = 1'b1;
    end else if (sum_nxt < drive_min_r) begin
      drive_nxt  = drive_min_r;
      dclamp_nxt = 1'b1;
    end
  end

  // control, history and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      last_lim_r  <= '0;
      last_err_r  <= '0;
      integ_r     <= '0;
      gain_p_r    <= 32'sd65536;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      gain_ff_r   <= '0;
      rate_up_r   <= S32_MAX;
      rate_dn_r   <= S32_MIN;
      drive_max_r <= S32_MAX;
      drive_min_r <= S32_MIN;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;

      if (en1 && v0_r) begin
        last_lim_r <= s0_cmd_r ? '0 : lim_nxt;
      end
      if (en2 && v1_r) begin
        last_err_r <= s1_cmd_r ? '0 : err_nxt;
      end
      if (en4 && v3_r && !s3_cmd_r) begin
        integ_r <= integ_nxt;
      end

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GAIN_P:    gain_p_r    <= cfg_wdata;
          CFG_GAIN_I:    gain_i_r    <= cfg_wdata;
          CFG_GAIN_D:    gain_d_r    <= cfg_wdata;
          CFG_GAIN_FF:   gain_ff_r   <= cfg_wdata;
          CFG_RATE_UP:   rate_up_r   <= cfg_wdata;
          CFG_RATE_DOWN: rate_dn_r   <= cfg_wdata;
          CFG_DRIVE_MAX: drive_max_r <= cfg_wdata;
          CFG_DRIVE_MIN: drive_min_r <= cfg_wdata;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en0) begin
      s0_cmd_r  <= in_command;
      s0_ref_r  <= in_reference;
      s0_meas_r <= in_measured;
    end
    if (en1) begin
      s1_cmd_r  <= s0_cmd_r;
      s1_lim_r  <= lim_nxt;
      s1_meas_r <= s0_meas_r;
    end
    if (en2) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_lim_r  <= s1_lim_r;
      s2_err_r  <= err_nxt;
      s2_derr_r <= derr_nxt;
    end
    if (en3) begin
      s3_cmd_r <= s2_cmd_r;
      s3_err_r <= s2_err_r;
      s3_p_r   <= qmul(gain_p_r, s2_err_r);
      s3_i_r   <= qmul(gain_i_r, s2_err_r);
      s3_d_r   <= qmul(gain_d_r, s2_derr_r);
      s3_f_r   <= qmul(gain_ff_r, s2_lim_r);
    end
    if (en4) begin
      s4_cmd_r    <= s3_cmd_r;
      s4_err_r    <= s3_err_r;
      s4_pdf_r    <= pdf_nxt;
      s4_iclamp_r <= iclamp_nxt;
    end
    if (en5) begin
      // history reset request answers with zeros
      out_drive_r  <= s4_cmd_r ? '0 : drive_nxt;
      out_err_r    <= s4_cmd_r ? '0 : s4_err_r;
      out_dclamp_r <= s4_cmd_r ? 1'b0 : dclamp_nxt;
      out_iclamp_r <= s4_cmd_r ? 1'b0 : s4_iclamp_r;
    end
  end

  assign out_valid            = v5_r;
  assign out_drive            = out_drive_r;
  assign out_loop_error       = out_err_r;
  assign out_drive_clamped    = out_dclamp_r;
  assign out_integral_clamped = out_iclamp_r;

  // backpressure only when every stage is full and the receiver stalls
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v0_r && v1_r && v2_r && v3_r && v4_r && v5_r && !out_ready))
    else $error("in_ready low with an empty stage");

  // a clamped integrator sits exactly on one of its bounds
  a_integ_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && s4_iclamp_r && !s4_cmd_r) |->
      (integ_r == INTEGRAL_UPPER || integ_r == INTEGRAL_LOWER))
    else $error("integrator clamp flag without bound value");

  // a clamped drive equals one of the configured limits
  a_drive_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drive_clamped) |->
      (out_drive == drive_max_r || out_drive == drive_min_r))
    else $error("drive clamp flag without limit value");

endmodule

>>> tb/sv/tb_pid_rate_limited_feedforward_core.sv
module tb_pid_rate_limited_feedforward_core
  import prlff_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] INTEG_HI = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INTEG_LO = 32'sh8000_0000;
  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam int unsigned LONG_HOLD = 100;
  localparam int unsigned RAND_PHASES = 7;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  typedef enum logic {
    CMD_RUN = 1'b0,
    CMD_CLEAR = 1'b1
  } ctl_cmd_t;

  typedef struct packed {
    ctl_cmd_t command;
    logic signed [31:0] reference;
    logic signed [31:0] measured;
  } ctl_req_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] loop_error;
    logic drive_clamped;
    logic integral_clamped;
  } ctl_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic signed [31:0] in_reference = '0;
  logic signed [31:0] in_measured = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_drive;
  logic signed [31:0] out_loop_error;
  logic out_drive_clamped;
  logic out_integral_clamped;

  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // controller registers and history as the block should hold them
  logic signed [31:0] ctl_regs [8] = '{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0,
                                       32'sh7FFF_FFFF, 32'sh8000_0000,
                                       32'sh7FFF_FFFF, 32'sh8000_0000};
  logic signed [31:0] prev_lim_ref = '0;
  logic signed [31:0] prev_err = '0;
  logic signed [31:0] integ_acc = '0;

  ctl_req_t req_q[$];
  ctl_result_t expected_q[$];
  int unsigned err_count = 0;
  bit no_idle = 1'b0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned gap_left = 0;
  logic signed [31:0] traj = '0;

  pid_rate_limited_feedforward_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_reference(in_reference),
    .in_measured(in_measured),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_drive(out_drive),
    .out_loop_error(out_loop_error),
    .out_drive_clamped(out_drive_clamped),
    .out_integral_clamped(out_integral_clamped),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fixmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip32(p >>> 16);
  endfunction

  // one control step; updates the history and integrator
  function automatic ctl_result_t pid_step(ctl_req_t r);
    ctl_result_t res;
    longint diff;
    logic signed [31:0] lim, err, pterm, dterm, fterm, sum;
    longint acc;
    res = '0;
    if (r.command == CMD_CLEAR) begin
      prev_lim_ref = '0;
      prev_err = '0;
      return res;
    end
    diff = longint'(r.reference) - longint'(prev_lim_ref);
    if (diff > longint'(ctl_regs[CFG_RATE_UP]))
      lim = clip32(longint'(prev_lim_ref) + longint'(ctl_regs[CFG_RATE_UP]));
    else if (diff < longint'(ctl_regs[CFG_RATE_DOWN]))
      lim = clip32(longint'(prev_lim_ref) + longint'(ctl_regs[CFG_RATE_DOWN]));
    else
      lim = r.reference;
    err = clip32(longint'(lim) - longint'(r.measured));
    pterm = fixmul(ctl_regs[CFG_GAIN_P], err);
    acc = longint'(clip32(longint'(integ_acc) + longint'(fixmul(ctl_regs[CFG_GAIN_I], err))));
    if (acc > longint'(INTEG_HI)) begin
      acc = longint'(INTEG_HI);
      res.integral_clamped = 1'b1;
    end else if (acc < longint'(INTEG_LO)) begin
      acc = longint'(INTEG_LO);
      res.integral_clamped = 1'b1;
    end
    integ_acc = acc[31:0];
    dterm = fixmul(ctl_regs[CFG_GAIN_D], clip32(longint'(err) - longint'(prev_err)));
    fterm = fixmul(ctl_regs[CFG_GAIN_FF], lim);
    sum = clip32(longint'(pterm) + longint'(integ_acc) + longint'(dterm) + longint'(fterm));
    if (sum > ctl_regs[CFG_DRIVE_MAX]) begin
      sum = ctl_regs[CFG_DRIVE_MAX];
      res.drive_clamped = 1'b1;
    end else if (sum < ctl_regs[CFG_DRIVE_MIN]) begin
      sum = ctl_regs[CFG_DRIVE_MIN];
      res.drive_clamped = 1'b1;
    end
    prev_lim_ref = lim;
    prev_err = err;
    res.drive = sum;
    res.loop_error = err;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %h, want %h", what, got, want);
    err_count++;
  endtask

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return 32'(int'($urandom_range(0, 32'h40000)) - 32'h20000);
      default: return $urandom;
    endcase
  endfunction

  // driver: sends queued requests, random gap after each accepted one
  always @(posedge clk) begin : drv
    bit take;
    ctl_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      take = in_valid && in_ready;
      if (take) begin
        nxt.command = ctl_cmd_t'(in_command);
        nxt.reference = in_reference;
        nxt.measured = in_measured;
        expected_q.push_back(pid_step(nxt));
      end
      if (in_valid && !take) begin
        // hold the request
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() > 0) begin
        nxt = req_q.pop_front();
        in_valid <= 1'b1;
        in_command <= nxt.command;
        in_reference <= nxt.reference;
        in_measured <= nxt.measured;
        gap_left <= (no_idle || $urandom_range(0, 9) < 7) ? 0 : pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks results, drives out_ready with random stalls
  always @(posedge clk) begin : mon
    ctl_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result drive", out_drive, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_drive !== want.drive)
            report_mismatch("drive", out_drive, want.drive);
          if (out_loop_error !== want.loop_error)
            report_mismatch("loop_error", out_loop_error, want.loop_error);
          if (out_drive_clamped !== want.drive_clamped)
            report_mismatch("drive_clamped", out_drive_clamped, want.drive_clamped);
          if (out_integral_clamped !== want.integral_clamped)
            report_mismatch("integral_clamped", out_integral_clamped, want.integral_clamped);
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) stall_left <= pick_idle();
      end
    end
  end

  task automatic add_req(ctl_cmd_t cmd, logic [31:0] ref_v, logic [31:0] meas_v);
    ctl_req_t r;
    r.command = cmd;
    r.reference = ref_v;
    r.measured = meas_v;
    req_q.push_back(r);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    ctl_regs[idx] = val;
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // mostly a wandering setpoint with a nearby measurement, some noise
  task automatic add_random_req();
    int unsigned r;
    int d;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      add_req(CMD_CLEAR, $urandom, $urandom);
    end else if (r < 15) begin
      add_req(CMD_RUN, rand_word(), rand_word());
    end else begin
      d = int'($urandom_range(0, 32'h60000)) - 32'h30000;
      traj = clip32(longint'(traj) + longint'(d));
      d = int'($urandom_range(0, 32'h20000)) - 32'h10000;
      add_req(CMD_RUN, traj, clip32(longint'(traj) + longint'(d)));
    end
  endtask

  task automatic load_profile(int unsigned k);
    logic [31:0] v [8];
    case (k)
      0: v = '{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX};
      1: v = '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN};
      // crossed rate and drive limits
      2: v = '{32'h0002_0000, 32'h0000_4000, 32'h0000_8000, 32'h0001_0000,
               32'hFFFF_FF00, 32'h0000_0100, 32'hFFFF_0000, 32'h0001_0000};
      default: begin
        v[CFG_GAIN_P] = 32'(int'($urandom_range(0, 32'h60000)) - 32'h30000);
        v[CFG_GAIN_I] = 32'(int'($urandom_range(0, 32'h8000)) - 32'h4000);
        v[CFG_GAIN_D] = 32'(int'($urandom_range(0, 32'h20000)) - 32'h10000);
        v[CFG_GAIN_FF] = 32'(int'($urandom_range(0, 32'h20000)) - 32'h10000);
        v[CFG_RATE_UP] = $urandom_range(0, 32'h40000);
        v[CFG_RATE_DOWN] = -$urandom_range(0, 32'h40000);
        v[CFG_DRIVE_MAX] = $urandom_range(32'h10000, 32'h400000);
        v[CFG_DRIVE_MIN] = -$urandom_range(32'h10000, 32'h400000);
        for (int i = 0; i < 8; i++)
          if ($urandom_range(0, 7) == 0) v[i] = rand_word();
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
    close_writes();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers: unit P gain, no limiting
    add_req(CMD_CLEAR, W_MAX, W_MIN);
    add_req(CMD_RUN, 32'h0001_0000, 32'h0);
    add_req(CMD_RUN, W_MAX, W_MIN);
    add_req(CMD_RUN, W_MIN, W_MAX);
    add_req(CMD_RUN, 32'h0, 32'h0);
    add_req(CMD_RUN, 32'hFFFF_FFFF, W_MAX);
    add_req(CMD_CLEAR, $urandom, $urandom);
    wait_drained();

    write_reg(CFG_GAIN_P, 32'h0002_0000);
    write_reg(CFG_GAIN_I, 32'h0000_8000);
    write_reg(CFG_GAIN_D, 32'h0001_0000);
    write_reg(CFG_GAIN_FF, 32'h0000_8000);
    write_reg(CFG_RATE_UP, 32'h0001_0000);
    write_reg(CFG_RATE_DOWN, 32'hFFFF_0000);
    write_reg(CFG_DRIVE_MAX, 32'h0003_0000);
    write_reg(CFG_DRIVE_MIN, 32'hFFFD_0000);
    close_writes();
    // rise and fall beyond the rate limits, in range, history clear, then runs after it
    add_req(CMD_RUN, 32'h0005_0000, 32'h0);
    add_req(CMD_RUN, 32'h0005_0000, 32'h0000_8000);
    add_req(CMD_RUN, 32'hFFFB_0000, 32'h0001_0000);
    add_req(CMD_RUN, 32'h0000_8000, 32'h0000_8000);
    add_req(CMD_RUN, 32'h0000_C000, 32'hFFFF_0000);
    add_req(CMD_RUN, W_MAX, W_MIN);
    add_req(CMD_CLEAR, W_MAX, W_MAX);
    add_req(CMD_RUN, W_MIN, W_MAX);
    add_req(CMD_RUN, 32'h0000_4000, 32'h0000_4000);
    add_req(CMD_RUN, 32'h0000_2000, 32'h0007_0000);
    wait_drained();

    for (int unsigned k = 0; k < RAND_PHASES; k++) begin
      load_profile(k);
      no_idle = (k == 4);
      traj = '0;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) add_random_req();
      // stall the receiver long enough to back the pipe up
      if (k == 3) hold_token <= hold_token + 1;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_pid_rate_limited_feedforward_core: done, clean");
    end else begin
      $display("tb_pid_rate_limited_feedforward_core: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_pid_rate_limited_feedforward_core: done, errors");
    $finish;
  end

endmodule

>>> pid_rate_limited_feedforward_core.f
rtl/prlff_pkg.sv
rtl/pid_rate_limited_feedforward_core.sv
tb/sv/tb_pid_rate_limited_feedforward_core.sv
